// ----- rtl/core/lr_pkg.sv -----
// Shared constants and types for the line rasterizer.
// Used by lr_ctrl, lr_dp and line_rasterizer; no dependencies.
package lr_pkg;

    localparam int COORD_BITS = 6;
    localparam int ERR_BITS   = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0]      t_coord;
    typedef logic signed [ERR_BITS-1:0] t_err;

    typedef struct packed {
        logic load;
        logic setup;
        logic step;
    } t_lr_cmd;

    typedef struct packed {
        logic last;
    } t_lr_stat;

endpackage

// ----- rtl/core/lr_ctrl.sv -----
// Controller for the line rasterizer: accept, setup and pixel emit sequencing.
// Depends on lr_pkg; drives lr_dp through t_lr_cmd and reads t_lr_stat.
module lr_ctrl import lr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_lr_stat i_stat,
    output t_lr_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_EMIT);

    always_comb begin
        o_cmd.load  = i_in_valid && o_in_ready;
        o_cmd.setup = (r_state == ST_SETUP);
        o_cmd.step  = o_out_valid && i_out_ready && !i_stat.last;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SETUP;
            end
            ST_SETUP: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_out_ready && i_stat.last) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/lr_dp.sv -----
// Datapath for the line rasterizer: endpoint registers, Bresenham error term,
// current pixel and step counter. Depends on lr_pkg; commanded by lr_ctrl.
module lr_dp import lr_pkg::*; (
    input  logic     i_clk,
    input  t_lr_cmd  i_cmd,
    input  t_coord   i_start_x,
    input  t_coord   i_start_y,
    input  t_coord   i_end_x,
    input  t_coord   i_end_y,
    output t_coord   o_pixel_x,
    output t_coord   o_pixel_y,
    output t_lr_stat o_stat
);

    t_coord r_px, r_py, r_ex, r_ey, r_cnt;
    logic   r_x_major, r_neg_x, r_neg_y;
    t_err   r_err, r_inc_move, r_inc_stay;

    t_coord w_adx, w_ady, w_major, w_minor;
    logic   w_x_major;
    t_err   w_major_e, w_minor_e;

    always_comb begin
        w_adx     = (r_ex >= r_px) ? (r_ex - r_px) : (r_px - r_ex);
        w_ady     = (r_ey >= r_py) ? (r_ey - r_py) : (r_py - r_ey);
        w_x_major = (w_adx > w_ady);
        w_major   = w_x_major ? w_adx : w_ady;
        w_minor   = w_x_major ? w_ady : w_adx;
        w_major_e = {{(ERR_BITS-COORD_BITS){1'b0}}, w_major};
        w_minor_e = {{(ERR_BITS-COORD_BITS){1'b0}}, w_minor};
    end

    assign o_pixel_x   = r_px;
    assign o_pixel_y   = r_py;
    assign o_stat.last = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_start_x;
            r_py <= i_start_y;
            r_ex <= i_end_x;
            r_ey <= i_end_y;
        end else if (i_cmd.setup) begin
            r_x_major  <= w_x_major;
            r_neg_x    <= (r_ex < r_px);
            r_neg_y    <= (r_ey < r_py);
            r_cnt      <= w_major;
            r_err      <= (w_minor_e <<< 1) - w_major_e;
            r_inc_move <= (w_minor_e - w_major_e) <<< 1;
            r_inc_stay <= w_minor_e <<< 1;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt - COORD_BITS'(1);
            if (!r_err[ERR_BITS-1]) begin
                r_err <= r_err + r_inc_move;
            end else begin
                r_err <= r_err + r_inc_stay;
            end
            if (r_x_major || !r_err[ERR_BITS-1]) begin
                r_px <= r_neg_x ? (r_px - COORD_BITS'(1)) : (r_px + COORD_BITS'(1));
            end
            if (!r_x_major || !r_err[ERR_BITS-1]) begin
                r_py <= r_neg_y ? (r_py - COORD_BITS'(1)) : (r_py + COORD_BITS'(1));
            end
        end
    end

endmodule

// ----- rtl/core/line_rasterizer.sv -----
// Line rasterizer top level: lr_ctrl sequences lr_dp.
// Depends on lr_pkg, lr_ctrl and lr_dp.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one line command:
//   start and end coordinates. Output channel (o_out_valid / i_out_ready)
//   carries one pixel per transaction, start point first, end point last,
//   with o_last_pixel set on the end point.
//   o_out_valid rises after the command is accepted and the setup state
//   (ST_SETUP) computes deltas and the error term; the first pixel
//   transaction follows that setup state. A line of major length M emits
//   M+1 pixels, one per cycle while the receiver is ready; a new command
//   is taken in the cycle after the last pixel leaves. The pixel step unit
//   is the single error-term add/compare per cycle.
//   The receiver may stall at any time: the current pixel holds in the
//   output register and the line resumes when i_out_ready returns.
//   Reset (synchronous, active low) drops any line in progress and
//   returns to idle, ready for a command.
module line_rasterizer import lr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_coord i_start_x,
    input  t_coord i_start_y,
    input  t_coord i_end_x,
    input  t_coord i_end_y,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_coord o_pixel_x,
    output t_coord o_pixel_y,
    output logic   o_last_pixel
);

    t_lr_cmd  w_cmd;
    t_lr_stat w_stat;

    lr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    lr_dp u_dp (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .o_pixel_x (o_pixel_x),
        .o_pixel_y (o_pixel_y),
        .o_stat    (w_stat)
    );

    assign o_last_pixel = w_stat.last;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("command accepted while pixels pending");

    a_setup_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (!o_out_valid && !o_in_ready))
        else $error("setup cycle skipped");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_pixel) |=> o_out_valid)
        else $error("line ended before its last pixel");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_pixel) |=> (o_in_ready && !o_out_valid))
        else $error("no return to idle after last pixel");
`endif

endmodule
